[rtl/core/hsp_pkg.sv]
`default_nettype none

package hsp_pkg;

    localparam int FUNC_W = 2;
    localparam int BYTE_W = 8;
    localparam int MASK_W = 3;
    localparam int COUNT_W = 16;
    localparam int DUTY_W = 8;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    localparam logic [FUNC_W-1:0] FUNC_TICK = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RX = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_FAST_RELOAD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOW_RELOAD = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEATER_ONE_DUTY = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEATER_TWO_DUTY = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BUZZER_ENABLE = 3'd4;

    localparam int MASK_TICK = 0;
    localparam int MASK_SECOND = 1;
    localparam int MASK_BYTE = 2;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [BYTE_W-1:0] received_byte;
        logic [MASK_W-1:0] clear_mask;
    } item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] fast_reload;
        logic [COUNT_W-1:0] slow_reload;
        logic [DUTY_W-1:0] heater_one_duty;
        logic [DUTY_W-1:0] heater_two_duty;
        logic buzzer_enable;
    } cfg_t;

    typedef struct packed {
        logic heater_one_on;
        logic heater_two_on;
        logic buzzer_level;
        logic tick_flag;
        logic second_flag;
    } timer_out_t;

    typedef struct packed {
        logic byte_valid;
        logic [BYTE_W-1:0] held_byte;
    } rx_out_t;

endpackage

`default_nettype wire

[rtl/core/hsp_cfg_regs.sv]
`default_nettype none

module hsp_cfg_regs (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [hsp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [hsp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    output hsp_pkg::cfg_t                            cfg
);

    hsp_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                hsp_pkg::CFG_FAST_RELOAD: begin
                    cfg_reg.fast_reload <= cfg_wdata;
                end
                hsp_pkg::CFG_SLOW_RELOAD: begin
                    cfg_reg.slow_reload <= cfg_wdata;
                end
                hsp_pkg::CFG_HEATER_ONE_DUTY: begin
                    cfg_reg.heater_one_duty <= cfg_wdata[hsp_pkg::DUTY_W-1:0];
                end
                hsp_pkg::CFG_HEATER_TWO_DUTY: begin
                    cfg_reg.heater_two_duty <= cfg_wdata[hsp_pkg::DUTY_W-1:0];
                end
                hsp_pkg::CFG_BUZZER_ENABLE: begin
                    cfg_reg.buzzer_enable <= cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[rtl/core/hsp_timer.sv]
`default_nettype none

module hsp_timer #(
    parameter int SLOTS = 50
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          step_en,
    input  wire hsp_pkg::item_t item,
    input  wire hsp_pkg::cfg_t  cfg,
    output hsp_pkg::timer_out_t next_out
);

    localparam int PHASE_W = $clog2(SLOTS);
    localparam logic [PHASE_W-1:0] LAST_SLOT = PHASE_W'(SLOTS - 1);

    logic [hsp_pkg::COUNT_W-1:0] fast_count_reg, fast_count_next;
    logic [hsp_pkg::COUNT_W-1:0] slow_count_reg, slow_count_next;
    logic [PHASE_W-1:0]          phase_reg, phase_next;
    hsp_pkg::timer_out_t         out_reg, out_next;

    always_comb begin
        fast_count_next = fast_count_reg;
        slow_count_next = slow_count_reg;
        phase_next = phase_reg;
        out_next = out_reg;
        case (item.func)
            hsp_pkg::FUNC_TICK: begin
                if (fast_count_reg == '0) begin
                    out_next.tick_flag = 1'b1;
                    fast_count_next = cfg.fast_reload;
                end else begin
                    fast_count_next = fast_count_reg - 1'b1;
                end
                if (slow_count_reg == '0) begin
                    if (phase_reg >= LAST_SLOT) begin
                        phase_next = '0;
                        out_next.second_flag = 1'b1;
                    end else begin
                        phase_next = phase_reg + 1'b1;
                    end
                    out_next.heater_one_on =
                        cfg.heater_one_duty > hsp_pkg::DUTY_W'(phase_next);
                    out_next.heater_two_on =
                        cfg.heater_two_duty > hsp_pkg::DUTY_W'(phase_next);
                    slow_count_next = cfg.slow_reload;
                end else begin
                    slow_count_next = slow_count_reg - 1'b1;
                end
                out_next.buzzer_level = cfg.buzzer_enable & ~out_reg.buzzer_level;
            end
            hsp_pkg::FUNC_CLEAR: begin
                if (item.clear_mask[hsp_pkg::MASK_TICK]) begin
                    out_next.tick_flag = 1'b0;
                end
                if (item.clear_mask[hsp_pkg::MASK_SECOND]) begin
                    out_next.second_flag = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fast_count_reg <= '0;
            slow_count_reg <= '0;
            phase_reg <= '0;
            out_reg <= '0;
        end else if (step_en) begin
            fast_count_reg <= fast_count_next;
            slow_count_reg <= slow_count_next;
            phase_reg <= phase_next;
            out_reg <= out_next;
        end
    end

    assign next_out = out_next;

endmodule

`default_nettype wire

[rtl/core/hsp_rx_latch.sv]
`default_nettype none

module hsp_rx_latch (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        step_en,
    input  wire hsp_pkg::item_t item,
    output hsp_pkg::rx_out_t next_out
);

    hsp_pkg::rx_out_t rx_reg, rx_next;

    always_comb begin
        rx_next = rx_reg;
        case (item.func)
            hsp_pkg::FUNC_RX: begin
                if (!rx_reg.byte_valid) begin
                    rx_next.held_byte = item.received_byte;
                end
                rx_next.byte_valid = 1'b1;
            end
            hsp_pkg::FUNC_CLEAR: begin
                if (item.clear_mask[hsp_pkg::MASK_BYTE]) begin
                    rx_next.byte_valid = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_reg <= '0;
        end else if (step_en) begin
            rx_reg <= rx_next;
        end
    end

    assign next_out = rx_next;

endmodule

`default_nettype wire

[rtl/core/heater_slot_pwm_timer.sv]
`default_nettype none

// Heater slot PWM timer. Accepts one word per clock while the result side
// keeps taking words. A word is first held in an input register and is applied
// to the block state when it moves into the result register, from which its
// result word is presented; while the result side stalls, the word waits in the
// input register. Timer tick words advance the fast and slow dividers and the
// SLOTS slot heater phase and toggle the buzzer when it is enabled; receive
// words latch a byte unless one is already held; clear words drop status flags
// by mask. Configuration writes take effect at once and are meant to be made
// while no word is in flight.
module heater_slot_pwm_timer #(
    parameter int SLOTS = 50
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output      logic                             s_tready,
    // [7:0] received_byte, [10:8] clear_mask, [15:11] zero
    input  wire logic [hsp_pkg::S_TDATA_W-1:0]    s_tdata,
    // [1:0] func
    input  wire logic [hsp_pkg::FUNC_W-1:0]       s_tuser,
    output      logic                             m_tvalid,
    input  wire logic                             m_tready,
    // [0] heater_one_on, [1] heater_two_on, [2] buzzer_level, [3] tick_flag,
    // [4] second_flag, [5] byte_valid, [13:6] held_byte, [15:14] zero
    output      logic [hsp_pkg::M_TDATA_W-1:0]    m_tdata,
    input  wire logic                             cfg_wr_en,
    input  wire logic [hsp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [hsp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int RESULT_W = 6 + hsp_pkg::BYTE_W;

    hsp_pkg::cfg_t       cfg;
    hsp_pkg::item_t      in_item_reg;
    hsp_pkg::timer_out_t timer_next;
    hsp_pkg::rx_out_t    rx_next;

    logic                            in_valid_reg, in_valid_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic [hsp_pkg::M_TDATA_W-1:0]   m_tdata_reg;
    logic                            s_accept;
    logic                            advance;

    assign advance = in_valid_reg & (~m_tvalid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;
    assign s_accept = s_tvalid & s_tready;

    assign in_valid_next = s_accept | (in_valid_reg & ~advance);
    assign m_tvalid_next = advance | (m_tvalid_reg & ~m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.func <= s_tuser;
            in_item_reg.received_byte <= s_tdata[hsp_pkg::BYTE_W-1:0];
            in_item_reg.clear_mask <=
                s_tdata[hsp_pkg::BYTE_W+hsp_pkg::MASK_W-1:hsp_pkg::BYTE_W];
        end
        if (advance) begin
            m_tdata_reg <= hsp_pkg::M_TDATA_W'({
                rx_next.held_byte,
                rx_next.byte_valid,
                timer_next.second_flag,
                timer_next.tick_flag,
                timer_next.buzzer_level,
                timer_next.heater_two_on,
                timer_next.heater_one_on
            });
        end
    end

    hsp_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    hsp_timer #(
        .SLOTS (SLOTS)
    ) u_timer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (advance),
        .item     (in_item_reg),
        .cfg      (cfg),
        .next_out (timer_next)
    );

    hsp_rx_latch u_rx_latch (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_en  (advance),
        .item     (in_item_reg),
        .next_out (rx_next)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;

    a_advance_gives_result: assert property (
        @(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid
    ) else $error("processed word did not produce a result");

    a_held_word_kept: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_item_reg))
    ) else $error("stalled input word was lost or changed");

    a_buzzer_quiet: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (advance && in_item_reg.func == hsp_pkg::FUNC_TICK && !cfg.buzzer_enable)
            |=> !m_tdata[2]
    ) else $error("buzzer toggled while disabled");

    a_rx_sets_valid: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (advance && in_item_reg.func == hsp_pkg::FUNC_RX) |=> m_tdata[5]
    ) else $error("received byte did not mark byte valid");

    a_result_width: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[hsp_pkg::M_TDATA_W-1:RESULT_W] == '0)
    ) else $error("result padding bits not zero");

endmodule

`default_nettype wire
